[src/audio_echo_delay_line_core_macros.svh]
// Assertion helpers for the echo delay line core.
// Both macros assume clk_i and rst_ni in the enclosing module.
`ifndef AUDIO_ECHO_DELAY_LINE_CORE_MACROS_SVH
`define AUDIO_ECHO_DELAY_LINE_CORE_MACROS_SVH
`ifndef NO_ASSERTIONS
`define AEDL_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("aedl assertion failed");
`define AEDL_NEVER(lbl, expr) \
  `AEDL_ASSERT(lbl, !(expr))
`else
`define AEDL_ASSERT(lbl, prop)
`define AEDL_NEVER(lbl, expr)
`endif
`endif

[src/aedl_pkg.sv]
package aedl_pkg;

  localparam int unsigned LINE_DEPTH  = 65536;
  localparam int unsigned ADDR_W      = $clog2(LINE_DEPTH);
  localparam int unsigned BLOCK_SHIFT = 7;
  localparam int unsigned SAMPLE_W    = 16;
  localparam int unsigned DELAY_W     = 9;
  localparam int unsigned WEIGHT_W    = 16;
  localparam int unsigned MODE_W      = 2;
  localparam int unsigned Q15_ONE     = 32768;
  localparam int unsigned Q15_SHIFT   = 15;

  localparam int unsigned PIPE_STAGES = 4;
  localparam int unsigned INFL_W      = $clog2(PIPE_STAGES + 1);
  localparam int unsigned FIFO_DEPTH  = 8;
  localparam int unsigned FIFO_AW     = $clog2(FIFO_DEPTH);
  localparam int unsigned CNT_W       = $clog2(FIFO_DEPTH + 1);

  localparam logic [1:0] REG_DELAY  = 2'd0;
  localparam logic [1:0] REG_WEIGHT = 2'd1;
  localparam logic [1:0] REG_MODE   = 2'd2;

  localparam logic [MODE_W-1:0] MODE_BYPASS = 2'd0;
  localparam logic [MODE_W-1:0] MODE_FF     = 2'd1;
  localparam logic [MODE_W-1:0] MODE_FB     = 2'd2;

  localparam logic [DELAY_W-1:0]  DELAY_RST  = 9'd1;
  localparam logic [WEIGHT_W-1:0] WEIGHT_RST = 16'd16384;

  // per-item control carried down the mix pipeline
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] dry;
    logic [MODE_W-1:0]          mode;
    logic [ADDR_W-1:0]          pos;
    logic                       first;   // item is in the first lap after reset
  } stage_t;

  typedef struct packed {
    logic                  valid;
    stage_t                st;
    logic [WEIGHT_W-1:0]   weight;       // already saturated to 1.0
    logic                  rd_ok;        // delayed entry has been written
  } req_t;

  typedef struct packed {
    logic                       valid;
    logic signed [SAMPLE_W-1:0] sample;
    logic                       we;
    logic [ADDR_W-1:0]          waddr;
    logic signed [SAMPLE_W-1:0] wdata;
  } res_t;

endpackage

[src/aedl_ram.sv]
module aedl_ram #(
  parameter int unsigned AW = 16,
  parameter int unsigned DW = 16
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem [2**AW];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[src/aedl_mix.sv]
module aedl_mix (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  aedl_pkg::req_t                             req_i,
  input  logic [aedl_pkg::SAMPLE_W-1:0]              rdata_i,
  output aedl_pkg::res_t                             res_o,
  output logic [aedl_pkg::INFL_W-1:0]                inflight_o
);

  localparam int unsigned PW = aedl_pkg::SAMPLE_W + aedl_pkg::WEIGHT_W + 1;
  localparam int unsigned PARTW = PW - aedl_pkg::Q15_SHIFT;
  localparam int unsigned SUMW = PW + 1;
  localparam int unsigned FULLW = SUMW - aedl_pkg::Q15_SHIFT;
  localparam logic signed [PW-1:0] P_BIAS = PW'((1 << aedl_pkg::Q15_SHIFT) - 1);
  localparam logic signed [SUMW-1:0] S_BIAS = SUMW'((1 << aedl_pkg::Q15_SHIFT) - 1);
  localparam logic signed [FULLW-1:0] S_MAX = FULLW'((1 << (aedl_pkg::SAMPLE_W - 1)) - 1);
  localparam logic signed [FULLW-1:0] S_MIN = -FULLW'(1 << (aedl_pkg::SAMPLE_W - 1));

  // stage 1: request, RAM data arrives alongside
  logic                              v1_q, v2_q, v3_q, v4_q;
  aedl_pkg::stage_t                  st1_q, st2_q, st3_q, st4_q;
  logic [aedl_pkg::WEIGHT_W-1:0]     w1_q;
  logic                              ok1_q;
  logic signed [PW-1:0]              p1_d, p1_q, p2_d, p2_q, p2b_q;
  logic signed [PARTW-1:0]           part_d, part_q;
  logic signed [SUMW-1:0]            sum_d, sum_q;
  logic signed [aedl_pkg::SAMPLE_W-1:0] wet;
  logic [aedl_pkg::WEIGHT_W-1:0]     inv_w;
  logic signed [PW-1:0]              p1_adj;
  logic signed [SUMW-1:0]            sum_adj;
  logic signed [FULLW-1:0]           full;
  logic signed [aedl_pkg::SAMPLE_W-1:0] mixed;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      v1_q <= req_i.valid;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    st1_q  <= req_i.st;
    w1_q   <= req_i.weight;
    ok1_q  <= req_i.rd_ok;
    st2_q  <= st1_q;
    p1_q   <= p1_d;
    p2_q   <= p2_d;
    st3_q  <= st2_q;
    part_q <= part_d;
    p2b_q  <= p2_q;
    st4_q  <= st3_q;
    sum_q  <= sum_d;
  end

  // stage 1: both Q15 products
  always_comb begin
    wet   = ok1_q ? $signed(rdata_i) : '0;
    inv_w = aedl_pkg::WEIGHT_W'(aedl_pkg::Q15_ONE - 32'(w1_q));
    p1_d  = PW'(st1_q.dry) * PW'($signed({1'b0, inv_w}));
    p2_d  = PW'(wet) * PW'($signed({1'b0, w1_q}));
  end

  // stage 2: dry part, truncated toward zero
  always_comb begin
    p1_adj = p1_q + (p1_q[PW-1] ? P_BIAS : '0);
    part_d = p1_adj[PW-1:aedl_pkg::Q15_SHIFT];
  end

  // stage 3: rejoin dry part with wet product
  always_comb begin
    sum_d = $signed({part_q[PARTW-1], part_q, {aedl_pkg::Q15_SHIFT{1'b0}}})
          + $signed({p2b_q[PW-1], p2b_q});
  end

  // stage 4: final truncation, clamp, store and result
  always_comb begin
    sum_adj = sum_q + (sum_q[SUMW-1] ? S_BIAS : '0);
    full    = sum_adj[SUMW-1:aedl_pkg::Q15_SHIFT];
    if (full > S_MAX) begin
      mixed = aedl_pkg::SAMPLE_W'(S_MAX);
    end else if (full < S_MIN) begin
      mixed = aedl_pkg::SAMPLE_W'(S_MIN);
    end else begin
      mixed = full[aedl_pkg::SAMPLE_W-1:0];
    end
    res_o.valid = v4_q;
    res_o.waddr = st4_q.pos;
    case (st4_q.mode)
      aedl_pkg::MODE_FF: begin
        res_o.sample = mixed;
        res_o.we     = v4_q;
        res_o.wdata  = st4_q.dry;
      end
      aedl_pkg::MODE_FB: begin
        res_o.sample = mixed;
        res_o.we     = v4_q;
        res_o.wdata  = mixed;
      end
      default: begin
        // bypass clears untouched entries during the first lap
        res_o.sample = st4_q.dry;
        res_o.we     = v4_q & st4_q.first;
        res_o.wdata  = '0;
      end
    endcase
  end

  assign inflight_o = aedl_pkg::INFL_W'(v1_q) + aedl_pkg::INFL_W'(v2_q)
                    + aedl_pkg::INFL_W'(v3_q) + aedl_pkg::INFL_W'(v4_q);

endmodule

[src/aedl_ofifo.sv]
module aedl_ofifo (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 push_i,
  input  logic [aedl_pkg::SAMPLE_W-1:0]        data_i,
  input  logic                                 pop_i,
  output logic                                 valid_o,
  output logic [aedl_pkg::SAMPLE_W-1:0]        data_o,
  output logic [aedl_pkg::CNT_W-1:0]           count_o
);

  logic [aedl_pkg::SAMPLE_W-1:0] buf_q [aedl_pkg::FIFO_DEPTH];
  logic [aedl_pkg::FIFO_AW-1:0]  wp_q, wp_d, rp_q, rp_d;
  logic [aedl_pkg::CNT_W-1:0]    cnt_q, cnt_d;
  logic                          pop;

  assign pop = pop_i & (cnt_q != '0);

  always_comb begin
    wp_d  = push_i ? wp_q + 1'b1 : wp_q;
    rp_d  = pop ? rp_q + 1'b1 : rp_q;
    cnt_d = cnt_q + aedl_pkg::CNT_W'(push_i) - aedl_pkg::CNT_W'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      buf_q[wp_q] <= data_i;
    end
  end

  assign valid_o = cnt_q != '0;
  assign data_o  = buf_q[rp_q];
  assign count_o = cnt_q;

endmodule

[src/audio_echo_delay_line_core.sv]
// Echo delay line: one signed 16-bit sample in, one mixed sample out.
// Input channel: in_valid_i / in_stall_o with sample_in_i; a transfer takes
// place when valid is high and stall is low. Output channel: out_valid_o /
// out_stall_i with sample_out_o, same rule.
// Configuration: cfg_we_i writes cfg_data_i into register cfg_idx_i
// (0 delay in 128-sample blocks, 1 Q15 wet weight, 2 mode); write only
// while no samples are in flight.
// Throughput: one sample per cycle while in_stall_o is low. The delay RAM
// does one read (issued on the input transfer) and at most one write (from
// the last mix stage; bypass writes only in the first lap) per sample. A
// sample runs through the registered mix pipeline into the output queue.
// An 8-entry output queue with credit counting sits before the output:
// in_stall_o rises only when queue plus pipeline hold 8 samples, so a
// stalled receiver backs up the queue and the input stall is registered-state
// only. Results never drop.
// Reset: the lap flag clears, the write position goes to 0 and registers take
// their defaults. No clearing pass: an entry not yet reached in the first lap
// reads as zero, and bypass writes zero during that lap.
`include "audio_echo_delay_line_core_macros.svh"

module audio_echo_delay_line_core (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic signed [aedl_pkg::SAMPLE_W-1:0]  sample_in_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic signed [aedl_pkg::SAMPLE_W-1:0]  sample_out_o,
  input  logic                                  cfg_we_i,
  input  logic [1:0]                            cfg_idx_i,
  input  logic [aedl_pkg::WEIGHT_W-1:0]         cfg_data_i
);

  logic [aedl_pkg::DELAY_W-1:0]  delay_q;
  logic [aedl_pkg::WEIGHT_W-1:0] weight_q;
  logic [aedl_pkg::MODE_W-1:0]   mode_q;
  logic [aedl_pkg::ADDR_W-1:0]   pos_q, pos_d;
  logic                          lap_q, lap_d;

  logic                          accept;
  logic [aedl_pkg::ADDR_W-1:0]   tap_dist;
  logic [aedl_pkg::ADDR_W-1:0]   ram_raddr;
  logic [aedl_pkg::SAMPLE_W-1:0] ram_rdata;
  logic [aedl_pkg::WEIGHT_W-1:0] w_sat;
  aedl_pkg::req_t                req;
  aedl_pkg::res_t                res;
  logic [aedl_pkg::INFL_W-1:0]   inflight;
  logic [aedl_pkg::CNT_W-1:0]    fifo_cnt;
  logic [aedl_pkg::CNT_W-1:0]    total;
  logic [aedl_pkg::SAMPLE_W-1:0] fifo_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_q  <= aedl_pkg::DELAY_RST;
      weight_q <= aedl_pkg::WEIGHT_RST;
      mode_q   <= aedl_pkg::MODE_BYPASS;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        aedl_pkg::REG_DELAY:  delay_q  <= cfg_data_i[aedl_pkg::DELAY_W-1:0];
        aedl_pkg::REG_WEIGHT: weight_q <= cfg_data_i;
        aedl_pkg::REG_MODE:   mode_q   <= cfg_data_i[aedl_pkg::MODE_W-1:0];
        default: ;
      endcase
    end
  end

  // credit check uses registered state only
  assign total      = aedl_pkg::CNT_W'(inflight) + fifo_cnt;
  assign in_stall_o = total >= aedl_pkg::CNT_W'(aedl_pkg::FIFO_DEPTH);
  assign accept     = in_valid_i & ~in_stall_o;

  always_comb begin
    tap_dist  = aedl_pkg::ADDR_W'({delay_q, {aedl_pkg::BLOCK_SHIFT{1'b0}}});
    ram_raddr = pos_q - tap_dist;
    w_sat     = (32'(weight_q) > aedl_pkg::Q15_ONE)
              ? aedl_pkg::WEIGHT_W'(aedl_pkg::Q15_ONE) : weight_q;
    pos_d     = accept ? pos_q + 1'b1 : pos_q;
    lap_d     = lap_q | (accept & (pos_q == aedl_pkg::ADDR_W'(aedl_pkg::LINE_DEPTH - 1)));
    req.valid    = accept;
    req.st.dry   = sample_in_i;
    req.st.mode  = mode_q;
    req.st.pos   = pos_q;
    req.st.first = ~lap_q;
    req.weight   = w_sat;
    // first lap: only positions already passed hold real data
    req.rd_ok    = lap_q | (ram_raddr < pos_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      lap_q <= 1'b0;
    end else begin
      pos_q <= pos_d;
      lap_q <= lap_d;
    end
  end

  // Writes in flight target positions 1..4 behind the current position, and a
  // tap is a multiple of 128 back, so no forwarding path is needed.
  aedl_ram #(
    .AW (aedl_pkg::ADDR_W),
    .DW (aedl_pkg::SAMPLE_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (res.we),
    .waddr_i (res.waddr),
    .wdata_i (res.wdata),
    .re_i    (accept),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  aedl_mix u_mix (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req),
    .rdata_i    (ram_rdata),
    .res_o      (res),
    .inflight_o (inflight)
  );

  aedl_ofifo u_ofifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res.valid),
    .data_i  (res.sample),
    .pop_i   (~out_stall_i),
    .valid_o (out_valid_o),
    .data_o  (fifo_data),
    .count_o (fifo_cnt)
  );

  assign sample_out_o = $signed(fifo_data);

  `AEDL_ASSERT(credit_bound, total <= aedl_pkg::CNT_W'(aedl_pkg::FIFO_DEPTH))
  `AEDL_NEVER(push_into_full, res.valid && out_stall_i && fifo_cnt[aedl_pkg::CNT_W-1])
  `AEDL_NEVER(rw_same_entry, accept && res.we && ram_raddr == res.waddr)
  `AEDL_ASSERT(lap_sticky, lap_q |=> lap_q)
  `AEDL_ASSERT(result_after_four, accept |-> ##4 res.valid)

endmodule

[test/tb_audio_echo_delay_line_core.sv]
`timescale 1ns / 1ps

module tb_audio_echo_delay_line_core;

  localparam longint Q_ONE          = 32768;
  localparam int     RANDOM_ITEMS   = 1150;
  localparam int     WATCHDOG_LIMIT = 4000;
  localparam logic [aedl_pkg::MODE_W-1:0] MODE_UNUSED = 2'd3;

  logic                                 clk_i       = 1'b0;
  logic                                 rst_ni      = 1'b0;
  logic                                 in_valid_i  = 1'b0;
  logic                                 in_stall_o;
  logic signed [aedl_pkg::SAMPLE_W-1:0] sample_in_i = '0;
  logic                                 out_valid_o;
  logic                                 out_stall_i = 1'b0;
  logic signed [aedl_pkg::SAMPLE_W-1:0] sample_out_o;
  logic                                 cfg_we_i    = 1'b0;
  logic [1:0]                           cfg_idx_i   = aedl_pkg::REG_DELAY;
  logic [aedl_pkg::WEIGHT_W-1:0]        cfg_data_i  = '0;

  audio_echo_delay_line_core dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .sample_in_i  (sample_in_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .sample_out_o (sample_out_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i)
  );

  always #10 clk_i = ~clk_i;

  // shadow of the delay line and its registers
  logic signed [aedl_pkg::SAMPLE_W-1:0] line_mem [aedl_pkg::LINE_DEPTH];
  logic [aedl_pkg::ADDR_W-1:0]          line_wr_pos = '0;
  logic [aedl_pkg::DELAY_W-1:0]         cfg_delay   = aedl_pkg::DELAY_RST;
  logic [aedl_pkg::WEIGHT_W-1:0]        cfg_weight  = aedl_pkg::WEIGHT_RST;
  logic [aedl_pkg::MODE_W-1:0]          cfg_mode    = aedl_pkg::MODE_BYPASS;

  logic signed [aedl_pkg::SAMPLE_W-1:0] pending_samples[$];
  logic signed [aedl_pkg::SAMPLE_W-1:0] expected_samples[$];

  int unsigned presented_cnt = 0;
  int unsigned taken_cnt     = 0;
  int unsigned error_cnt     = 0;
  int unsigned idle_cycles   = 0;
  int unsigned burst_left    = 0;
  int unsigned gap_left      = 0;
  int unsigned stall_left    = 0;
  int unsigned stall_pct     = 0;

  // mix one dry sample with the tapped one and update the line
  function automatic logic signed [aedl_pkg::SAMPLE_W-1:0] compute_echo_sample(
      input logic signed [aedl_pkg::SAMPLE_W-1:0] dry);
    logic [aedl_pkg::ADDR_W-1:0]          rd_pos;
    longint                               w;
    longint                               part;
    longint                               sum;
    logic signed [aedl_pkg::SAMPLE_W-1:0] res;
    rd_pos = line_wr_pos - {cfg_delay, 7'd0};
    w = (cfg_weight > Q_ONE) ? Q_ONE : longint'(cfg_weight);
    part = (longint'(dry) * (Q_ONE - w)) / Q_ONE;
    sum = (part * Q_ONE + longint'(line_mem[rd_pos]) * w) / Q_ONE;
    if (sum > 32767) sum = 32767;
    if (sum < -32768) sum = -32768;
    case (cfg_mode)
      aedl_pkg::MODE_FF: begin
        line_mem[line_wr_pos] = dry;
        res = sum[aedl_pkg::SAMPLE_W-1:0];
      end
      aedl_pkg::MODE_FB: begin
        line_mem[line_wr_pos] = sum[aedl_pkg::SAMPLE_W-1:0];
        res = sum[aedl_pkg::SAMPLE_W-1:0];
      end
      default: res = dry;
    endcase
    line_wr_pos = line_wr_pos + 1'b1;
    return res;
  endfunction

  function automatic logic signed [aedl_pkg::SAMPLE_W-1:0] draw_sample();
    logic signed [aedl_pkg::SAMPLE_W-1:0] s;
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 4))
          0: s = 16'sh7fff;
          1: s = 16'sh8000;
          2: s = -16'sd1;
          3: s = 16'sd0;
          default: s = 16'sd1;
        endcase
      end
      1, 2, 3: begin
        s = 16'($urandom_range(0, 4095));
        s = s - 16'sd2048;
      end
      default: s = 16'($urandom);
    endcase
    return s;
  endfunction

  // wait for the line to go idle, then write all three registers
  task automatic reprogram(input logic [15:0] d_word, w_word, m_word);
    while (pending_samples.size() != 0 || expected_samples.size() != 0)
      @(posedge clk_i);
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= aedl_pkg::REG_DELAY;
    cfg_data_i <= d_word;
    @(negedge clk_i);
    cfg_idx_i  <= aedl_pkg::REG_WEIGHT;
    cfg_data_i <= w_word;
    @(negedge clk_i);
    cfg_idx_i  <= aedl_pkg::REG_MODE;
    cfg_data_i <= m_word;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    @(posedge clk_i);
    cfg_delay  = d_word[aedl_pkg::DELAY_W-1:0];
    cfg_weight = w_word;
    cfg_mode   = m_word[aedl_pkg::MODE_W-1:0];
  endtask

  // sender: bursts with random gaps, payload held until the transfer
  always @(negedge clk_i) begin
    if (presented_cnt == taken_cnt) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid_i <= 1'b0;
      end else if (pending_samples.size() > 0) begin
        in_valid_i  <= 1'b1;
        sample_in_i <= pending_samples[0];
        presented_cnt++;
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 40);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // receiver: stall density changes from one stretch to the next
  always @(negedge clk_i) begin
    if (stall_left == 0) begin
      stall_left = $urandom_range(5, 60);
      case ($urandom_range(0, 5))
        0, 1: stall_pct = 0;
        2: stall_pct = 25;
        3: stall_pct = 50;
        4: stall_pct = 85;
        default: begin
          stall_pct  = 100;
          stall_left = $urandom_range(1, 20);
        end
      endcase
    end
    stall_left--;
    out_stall_i <= ($urandom_range(0, 99) < stall_pct);
  end

  // input transfer: predict the result
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) begin
      expected_samples.push_back(compute_echo_sample(sample_in_i));
      void'(pending_samples.pop_front());
      taken_cnt++;
    end
  end

  // output transfer: check against the oldest prediction
  always @(posedge clk_i) begin
    logic signed [aedl_pkg::SAMPLE_W-1:0] exp_sample;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_samples.size() == 0) begin
        error_cnt++;
        if (error_cnt <= 10)
          $display("unexpected output sample %0d", sample_out_o);
      end else begin
        exp_sample = expected_samples.pop_front();
        if (sample_out_o !== exp_sample) begin
          error_cnt++;
          if (error_cnt <= 10)
            $display("sample_out mismatch: expected %0d got %0d", exp_sample, sample_out_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    int unsigned                  random_cnt;
    int unsigned                  n;
    logic [aedl_pkg::DELAY_W-1:0] d;
    logic [15:0]                  d_word;
    logic [15:0]                  w_word;
    logic [15:0]                  m_word;
    for (int i = 0; i < aedl_pkg::LINE_DEPTH; i++) line_mem[i] = '0;
    random_cnt = 0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset defaults: bypass
    pending_samples.push_back(16'sh7fff);
    pending_samples.push_back(16'sh8000);
    pending_samples.push_back(16'sd0);
    pending_samples.push_back(-16'sd1);
    pending_samples.push_back(16'sh5a5a);
    // zero distance taps the entry about to be written, full wet
    reprogram(16'd0, 16'd32768, {14'd0, aedl_pkg::MODE_FF});
    pending_samples.push_back(16'sh7fff);
    pending_samples.push_back(16'sh8000);
    pending_samples.push_back(16'sh1234);
    // dry only, feedback
    reprogram(16'd1, 16'd0, {14'd0, aedl_pkg::MODE_FB});
    pending_samples.push_back(16'sh8000);
    pending_samples.push_back(16'sh7fff);
    pending_samples.push_back(16'sd7);
    // unused mode behaves as bypass; junk in the upper data bits
    reprogram(16'hfe01, 16'hffff, {14'h3fff, MODE_UNUSED});
    pending_samples.push_back(-16'sd1);
    pending_samples.push_back(16'sd100);
    // longest delay, weight above one saturates
    reprogram(16'd511, 16'h8001, {14'd0, aedl_pkg::MODE_FF});
    pending_samples.push_back(16'sh7fff);
    pending_samples.push_back(16'sh8000);
    // smallest nonzero weight
    reprogram(16'd1, 16'd1, {14'd0, aedl_pkg::MODE_FB});
    pending_samples.push_back(16'sh8000);
    pending_samples.push_back(16'sh7fff);

    while (random_cnt < RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: d = aedl_pkg::DELAY_W'($urandom_range(1, 4));
        4, 5: d = aedl_pkg::DELAY_W'($urandom_range(5, 10));
        6: d = '0;
        7: d = aedl_pkg::DELAY_W'(511);
        8: d = aedl_pkg::DELAY_W'($urandom_range(11, 511));
        default: d = aedl_pkg::DELAY_W'(1);
      endcase
      d_word = 16'($urandom);
      if ($urandom_range(0, 1) == 0) d_word = '0;
      d_word[aedl_pkg::DELAY_W-1:0] = d;
      case ($urandom_range(0, 7))
        0: w_word = 16'd0;
        1: w_word = 16'd32768;
        2: w_word = 16'hffff;
        3: w_word = 16'($urandom_range(32769, 65535));
        4: w_word = 16'd32767;
        default: w_word = 16'($urandom_range(0, 32768));
      endcase
      m_word = 16'($urandom);
      if ($urandom_range(0, 1) == 0) m_word = '0;
      case ($urandom_range(0, 7))
        0: m_word[aedl_pkg::MODE_W-1:0] = aedl_pkg::MODE_BYPASS;
        1: m_word[aedl_pkg::MODE_W-1:0] = MODE_UNUSED;
        2, 3, 4: m_word[aedl_pkg::MODE_W-1:0] = aedl_pkg::MODE_FF;
        default: m_word[aedl_pkg::MODE_W-1:0] = aedl_pkg::MODE_FB;
      endcase
      reprogram(d_word, w_word, m_word);
      n = $urandom_range(30, 150);
      if (n > RANDOM_ITEMS - random_cnt) n = RANDOM_ITEMS - random_cnt;
      repeat (n) pending_samples.push_back(draw_sample());
      random_cnt += n;
    end

    while (pending_samples.size() != 0 || expected_samples.size() != 0)
      @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (expected_samples.size() != 0) error_cnt++;
    if (error_cnt == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
